FILE: hdl/jqc_pkg.sv
// ----------------------------------------------------------------------------
// Job queue with cancel-last: shared package
// Port widths, default sizes, transaction and result codes, and the
// command and status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package jqc_pkg;

   // Fixed widths of the transaction fields.
   localparam int KIND_W   = 2;
   localparam int JOB_ID_W = 16;
   localparam int STATUS_W = 4;
   localparam int PCOUNT_W = 6;

   // Default sizes for the top level parameters.
   localparam int DEF_QUEUE_DEPTH = 32;
   localparam int DEF_STACK_DEPTH = 32;
   localparam int DEF_SET_DEPTH   = 32;
   localparam int DEF_ID_BITS     = 16;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DRAIN  = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] RSP_ADDED        = 4'd0;
   localparam logic [STATUS_W-1:0] RSP_QUEUE_FULL   = 4'd1;
   localparam logic [STATUS_W-1:0] RSP_CANCEL_MARK  = 4'd2;
   localparam logic [STATUS_W-1:0] RSP_NO_CANCEL    = 4'd3;
   localparam logic [STATUS_W-1:0] RSP_PRINTED      = 4'd4;
   localparam logic [STATUS_W-1:0] RSP_SKIPPED      = 4'd5;
   localparam logic [STATUS_W-1:0] RSP_DRAIN_DONE   = 4'd6;
   localparam logic [STATUS_W-1:0] RSP_QUEUE_EMPTY  = 4'd7;
   localparam logic [STATUS_W-1:0] RSP_SET_FULL     = 4'd8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CANCEL,
      ST_DRAIN,
      ST_DONE
   } jqc_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic add;
      logic cancel;
      logic drain_start;
      logic drain_job;
      logic drain_done;
      logic drain_empty;
   } jqc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic queue_empty;
      logic queue_last;
   } jqc_stat_type;

endpackage

FILE: hdl/jqc_ctrl.sv
// ----------------------------------------------------------------------------
// Job queue with cancel-last: controller
// Sequences add, cancel and drain transactions and issues datapath commands.
// ----------------------------------------------------------------------------
module jqc_ctrl
   import jqc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [KIND_W-1:0] kind,
   input  jqc_stat_type      stat,
   output jqc_cmd_type       cmd,
   output logic              busy
);

   jqc_state_type state_ff;
   jqc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (accept) begin
               case (kind)
                  KIND_ADD: begin
                     cmd.add = 1'b1;
                  end
                  KIND_CANCEL: begin
                     // The stack top is read on this edge and used next cycle.
                     state_in = ST_CANCEL;
                  end
                  KIND_DRAIN: begin
                     if (stat.queue_empty) begin
                        cmd.drain_empty = 1'b1;
                     end else begin
                        cmd.drain_start = 1'b1;
                        state_in        = ST_DRAIN;
                     end
                  end
                  default: begin
                     // Unused kind: accepted and ignored.
                  end
               endcase
            end
         end
         ST_CANCEL: begin
            cmd.cancel = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_DRAIN: begin
            cmd.drain_job = 1'b1;
            if (stat.queue_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.drain_done = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/jqc_dp.sv
// ----------------------------------------------------------------------------
// Job queue with cancel-last: datapath
// Job FIFO memory, circular undo stack memory, revoked-id match set and the
// registered result outputs.
// ----------------------------------------------------------------------------
module jqc_dp
   import jqc_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int STACK_DEPTH = DEF_STACK_DEPTH,
   parameter int SET_DEPTH   = DEF_SET_DEPTH,
   parameter int ID_BITS     = DEF_ID_BITS
)(
   input  logic                clock,
   input  logic                reset,
   input  jqc_cmd_type         cmd,
   input  logic [JOB_ID_W-1:0] job_id,
   output jqc_stat_type        stat,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [JOB_ID_W-1:0] rsp_result_id,
   output logic [PCOUNT_W-1:0] rsp_printed_count,
   output logic                rsp_last
);

   localparam int QIDX_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SIDX_W = $clog2(STACK_DEPTH);
   localparam int SCNT_W = $clog2(STACK_DEPTH + 1);

   // Memories.
   logic [ID_BITS-1:0] fifo_ram  [QUEUE_DEPTH];
   logic [ID_BITS-1:0] stack_ram [STACK_DEPTH];
   logic [ID_BITS-1:0] fifo_rd_ff;
   logic [ID_BITS-1:0] stack_rd_ff;

   // FIFO pointers.
   logic [QIDX_W-1:0]  head_ff, head_in, head_inc, tail, rd_addr;
   logic [QCNT_W-1:0]  fill_ff, fill_in;
   logic [QCNT_W:0]    tail_sum;

   // Undo stack: write pointer and count of a circular buffer.
   logic [SIDX_W-1:0]  sptr_ff, sptr_in, sptr_inc, sptr_dec;
   logic [SCNT_W-1:0]  scnt_ff, scnt_in;

   // Revoked-id set.
   logic [ID_BITS-1:0]   set_ids_ff [SET_DEPTH];
   logic [SET_DEPTH-1:0] set_valid_ff, set_valid_in;
   logic [SET_DEPTH-1:0] set_match, set_free, set_free_one, set_we;
   logic [ID_BITS-1:0]   key;
   logic                 hit;

   logic [QCNT_W-1:0]  printed_ff, printed_in;
   logic [ID_BITS-1:0] new_id;
   logic               q_full;
   logic               fifo_we, stack_we;

   // Result registers.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_BITS-1:0]  rid_ff, rid_in;
   logic [QCNT_W-1:0]   pcount_ff, pcount_in;
   logic                last_ff, last_in;

   assign new_id   = ID_BITS'(job_id);
   assign q_full   = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_inc = (head_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_sum = (QCNT_W + 1)'(head_ff) + (QCNT_W + 1)'(fill_ff);
   assign tail     = (tail_sum >= (QCNT_W + 1)'(QUEUE_DEPTH))
                     ? QIDX_W'(tail_sum - (QCNT_W + 1)'(QUEUE_DEPTH))
                     : QIDX_W'(tail_sum);
   assign rd_addr  = cmd.drain_job ? head_inc : head_ff;
   assign sptr_inc = (sptr_ff == SIDX_W'(STACK_DEPTH - 1)) ? '0 : sptr_ff + 1'b1;
   assign sptr_dec = (sptr_ff == '0) ? SIDX_W'(STACK_DEPTH - 1) : sptr_ff - 1'b1;

   assign stat.queue_empty = (fill_ff == '0);
   assign stat.queue_last  = (fill_ff == QCNT_W'(1));

   // Match against every stored id; ids in the set are unique.
   assign key = cmd.cancel ? stack_rd_ff : fifo_rd_ff;
   always_comb begin
      for (int i = 0; i < SET_DEPTH; i++) begin
         set_match[i] = set_valid_ff[i] && (set_ids_ff[i] == key);
      end
   end
   assign hit          = |set_match;
   assign set_free     = ~set_valid_ff;
   assign set_free_one = set_free & (~set_free + SET_DEPTH'(1));

   always_comb begin
      head_in      = head_ff;
      fill_in      = fill_ff;
      sptr_in      = sptr_ff;
      scnt_in      = scnt_ff;
      set_valid_in = set_valid_ff;
      set_we       = '0;
      printed_in   = printed_ff;
      fifo_we      = 1'b0;
      stack_we     = 1'b0;
      rsp_valid_in = 1'b0;
      status_in    = RSP_ADDED;
      rid_in       = '0;
      pcount_in    = '0;
      last_in      = 1'b1;

      if (cmd.add) begin
         rsp_valid_in = 1'b1;
         rid_in       = new_id;
         if (q_full) begin
            status_in = RSP_QUEUE_FULL;
         end else begin
            status_in = RSP_ADDED;
            fifo_we   = 1'b1;
            fill_in   = fill_ff + 1'b1;
            // A full stack overwrites its oldest entry at the write pointer.
            stack_we  = 1'b1;
            sptr_in   = sptr_inc;
            if (scnt_ff != SCNT_W'(STACK_DEPTH)) begin
               scnt_in = scnt_ff + 1'b1;
            end
         end
      end

      if (cmd.cancel) begin
         rsp_valid_in = 1'b1;
         if (scnt_ff == '0) begin
            status_in = RSP_NO_CANCEL;
         end else if (hit || (|set_free)) begin
            status_in = RSP_CANCEL_MARK;
            rid_in    = stack_rd_ff;
            sptr_in   = sptr_dec;
            scnt_in   = scnt_ff - 1'b1;
            if (!hit) begin
               set_we       = set_free_one;
               set_valid_in = set_valid_ff | set_free_one;
            end
         end else begin
            status_in = RSP_SET_FULL;
            rid_in    = stack_rd_ff;
         end
      end

      if (cmd.drain_start) begin
         printed_in = '0;
      end

      if (cmd.drain_job) begin
         rsp_valid_in = 1'b1;
         rid_in       = fifo_rd_ff;
         last_in      = 1'b0;
         head_in      = head_inc;
         fill_in      = fill_ff - 1'b1;
         if (hit) begin
            status_in    = RSP_SKIPPED;
            set_valid_in = set_valid_ff & ~set_match;
         end else begin
            status_in  = RSP_PRINTED;
            printed_in = printed_ff + 1'b1;
         end
      end

      if (cmd.drain_done) begin
         rsp_valid_in = 1'b1;
         status_in    = RSP_DRAIN_DONE;
         pcount_in    = printed_ff;
      end

      if (cmd.drain_empty) begin
         rsp_valid_in = 1'b1;
         status_in    = RSP_QUEUE_EMPTY;
      end
   end

   // Memories: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_ram[tail] <= new_id;
      end
      fifo_rd_ff <= fifo_ram[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_ram[sptr_ff] <= new_id;
      end
      stack_rd_ff <= stack_ram[sptr_dec];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SET_DEPTH; i++) begin
         if (set_we[i]) begin
            set_ids_ff[i] <= stack_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         sptr_ff      <= '0;
         scnt_ff      <= '0;
         set_valid_ff <= '0;
         printed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         sptr_ff      <= sptr_in;
         scnt_ff      <= scnt_in;
         set_valid_ff <= set_valid_in;
         printed_ff   <= printed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rid_ff    <= rid_in;
      pcount_ff <= pcount_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_result_id     = JOB_ID_W'(rid_ff);
   assign rsp_printed_count = PCOUNT_W'(pcount_ff);
   assign rsp_last          = last_ff;

endmodule

FILE: hdl/job_queue_with_cancel_last_unit.sv
// ----------------------------------------------------------------------------
// Job queue with cancel-last: top level
// A cancel first reads the stack top; each result is on the rsp_ ports the
// cycle after its work is done, for one cycle only, as the receiver cannot stall.
// A drain reads one queued job per cycle through the FIFO memory read port, then
// gives a summary; a drain of an empty queue gives only a QUEUE_EMPTY result.
// Synchronous reset empties queue, stack and revoked set at once (no sweep).
// ----------------------------------------------------------------------------
module job_queue_with_cancel_last_unit
   import jqc_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int STACK_DEPTH = DEF_STACK_DEPTH,
   parameter int SET_DEPTH   = DEF_SET_DEPTH,
   parameter int ID_BITS     = DEF_ID_BITS
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [JOB_ID_W-1:0] req_job_id,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [JOB_ID_W-1:0] rsp_result_id,
   output logic [PCOUNT_W-1:0] rsp_printed_count,
   output logic                rsp_last
);

   // A transaction is taken whenever start is high while the controller is
   // idle. Adds can therefore follow each other in every cycle, while a
   // cancel or a non-empty drain holds busy until its last result is registered.
   logic        accept;
   jqc_cmd_type cmd;
   jqc_stat_type stat;

   assign accept = start && !busy;

   // The controller decides which operation runs in each cycle; it sees only
   // accept, the request kind and two fill flags from the datapath.
   jqc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .kind   (req_kind),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   // The datapath holds the job FIFO, the undo stack and the revoked-id set.
   // A drain reads one FIFO entry per cycle, checks it against the whole set
   // in parallel, and clears the matching mark in the same cycle, so a later
   // job with the same id sees the updated set.
   jqc_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .STACK_DEPTH (STACK_DEPTH),
      .SET_DEPTH   (SET_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .job_id            (req_job_id),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_printed_count (rsp_printed_count),
      .rsp_last          (rsp_last)
   );

endmodule

FILE: tb/job_queue_with_cancel_last_unit_tb.sv
// ----------------------------------------------------------------------------
// Job queue with cancel-last: self-checking testbench
// Transactions go to the unit through the start/busy command port. A local
// copy of the job FIFO, the undo stack and the revoked-id set predicts every
// result, and each strobed result is compared field by field with the oldest
// prediction. Directed cases come first. Then come the full-queue,
// stack-overflow and full-set scenarios, and then random traffic under
// several sender idling patterns.
// ----------------------------------------------------------------------------
module job_queue_with_cancel_last_unit_tb;
   import jqc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Kind 3 is not a legal request. The unit must accept it and ignore it.
   localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

   localparam int QDEPTH = DEF_QUEUE_DEPTH;
   localparam int SDEPTH = DEF_STACK_DEPTH;
   localparam int RDEPTH = DEF_SET_DEPTH;

   // Cycles to wait after the last expected result. A full drain is the
   // longest piece of work.
   localparam int SETTLE_CYCLES = QDEPTH + 8;
   localparam int DRAIN_WAIT_LIMIT = 20000;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [JOB_ID_W-1:0] job_id;
      logic [PCOUNT_W-1:0] printed;
      logic                last;
   } job_outcome_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [KIND_W-1:0]   req_kind;
   logic [JOB_ID_W-1:0] req_job_id;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [JOB_ID_W-1:0] rsp_result_id;
   logic [PCOUNT_W-1:0] rsp_printed_count;
   logic                rsp_last;

   job_queue_with_cancel_last_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_job_id        (req_job_id),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_printed_count (rsp_printed_count),
      .rsp_last          (rsp_last)
   );

   // The testbench keeps its own copy of the unit's state. The job FIFO is
   // a circular buffer, the undo stack grows upward from entry zero, and the
   // revoked set is a bank of slots with valid bits.
   logic [JOB_ID_W-1:0] queue_ids [QDEPTH];
   int unsigned         queue_head;
   int unsigned         queue_fill;
   logic [JOB_ID_W-1:0] undo_ids [SDEPTH];
   int unsigned         undo_top;
   logic [JOB_ID_W-1:0] revoked_ids [RDEPTH];
   logic                revoked_valid [RDEPTH];

   job_outcome_type     expected_outcomes [$];
   int unsigned         error_count;
   logic [JOB_ID_W-1:0] id_pool [8];

   // Free-running clock with an 8 ns period.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog. Even the slowest legal run of every test is far shorter.
   initial begin
      #2_000_000;
      $display("job_queue_with_cancel_last_unit_tb NOT OK");
      $finish;
   end

   // Queue one predicted result.
   task automatic push_outcome(input logic [STATUS_W-1:0] status,
                               input logic [JOB_ID_W-1:0] job_id,
                               input logic [PCOUNT_W-1:0] printed,
                               input logic last);
      job_outcome_type outcome;
      outcome.status  = status;
      outcome.job_id  = job_id;
      outcome.printed = printed;
      outcome.last    = last;
      expected_outcomes.push_back(outcome);
   endtask

   // Find the revoked-set slot that holds an id. The result is RDEPTH if
   // no slot holds it.
   function automatic int find_revoked(input logic [JOB_ID_W-1:0] job_id);
      for (int i = 0; i < RDEPTH; i++) begin
         if (revoked_valid[i] && revoked_ids[i] == job_id) return i;
      end
      return RDEPTH;
   endfunction

   // Work out the results of one accepted transaction and advance the local
   // state to match.
   task automatic predict_outcomes(input logic [KIND_W-1:0] kind,
                                   input logic [JOB_ID_W-1:0] job_id);
      logic [JOB_ID_W-1:0] victim;
      logic [JOB_ID_W-1:0] job;
      int                  slot;
      int unsigned         printed;
      case (kind)
         KIND_ADD: begin
            if (queue_fill >= QDEPTH) begin
               // A full queue drops the job and leaves the undo stack alone.
               push_outcome(RSP_QUEUE_FULL, job_id, '0, 1'b1);
            end else begin
               queue_ids[(queue_head + queue_fill) % QDEPTH] = job_id;
               queue_fill++;
               if (undo_top >= SDEPTH) begin
                  // A full stack loses its oldest entry to make room.
                  for (int i = 0; i < SDEPTH - 1; i++) undo_ids[i] = undo_ids[i + 1];
                  undo_top = SDEPTH - 1;
               end
               undo_ids[undo_top] = job_id;
               undo_top++;
               push_outcome(RSP_ADDED, job_id, '0, 1'b1);
            end
         end
         KIND_CANCEL: begin
            if (undo_top == 0) begin
               push_outcome(RSP_NO_CANCEL, '0, '0, 1'b1);
            end else begin
               victim = undo_ids[undo_top - 1];
               slot = RDEPTH;
               if (find_revoked(victim) == RDEPTH) begin
                  for (int i = RDEPTH - 1; i >= 0; i--) begin
                     if (!revoked_valid[i]) slot = i;
                  end
                  if (slot < RDEPTH) begin
                     revoked_ids[slot] = victim;
                     revoked_valid[slot] = 1'b1;
                  end
               end else begin
                  // The id is already revoked. The stack still pops.
                  slot = 0;
               end
               if (slot == RDEPTH) begin
                  // The set is full. Nothing is popped or marked.
                  push_outcome(RSP_SET_FULL, victim, '0, 1'b1);
               end else begin
                  undo_top--;
                  push_outcome(RSP_CANCEL_MARK, victim, '0, 1'b1);
               end
            end
         end
         KIND_DRAIN: begin
            if (queue_fill == 0) begin
               push_outcome(RSP_QUEUE_EMPTY, '0, '0, 1'b1);
            end else begin
               printed = 0;
               while (queue_fill > 0) begin
                  job = queue_ids[queue_head];
                  slot = find_revoked(job);
                  queue_head = (queue_head + 1) % QDEPTH;
                  queue_fill--;
                  if (slot < RDEPTH) begin
                     // A revoked job is skipped, and that uses up its mark.
                     revoked_valid[slot] = 1'b0;
                     push_outcome(RSP_SKIPPED, job, '0, 1'b0);
                  end else begin
                     printed++;
                     push_outcome(RSP_PRINTED, job, '0, 1'b0);
                  end
               end
               push_outcome(RSP_DRAIN_DONE, '0, PCOUNT_W'(printed), 1'b1);
            end
         end
         default: begin
            // An ignored kind changes nothing and gives no result.
         end
      endcase
   endtask

   // Send one transaction. With the given probability the sender first
   // holds start low and drives random values on the request fields, and
   // may do so again. Start stays high from one transaction to the next when
   // there is no gap, so it is never lowered and raised in the same step.
   // The transaction is taken at the first edge where busy is low. At that
   // point the task still sees the values from before the edge.
   task automatic issue_transaction(input logic [KIND_W-1:0] kind,
                                    input logic [JOB_ID_W-1:0] job_id,
                                    input int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start      <= 1'b0;
         req_kind   <= KIND_W'($urandom);
         req_job_id <= JOB_ID_W'($urandom);
         @(posedge clock);
      end
      start      <= 1'b1;
      req_kind   <= kind;
      req_job_id <= job_id;
      do @(posedge clock); while (busy);
      predict_outcomes(kind, job_id);
   endtask

   // Stop sending. Called at an edge, after the last transaction.
   task automatic stop_sending;
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Opening cases at the edges of the fields. These cover a drain and a
   // cancel on an empty unit, the ignored kind, the smallest and largest id,
   // a cancel of an id that is already revoked, and a drain that both skips
   // and prints jobs.
   task automatic test_directed_cases;
      issue_transaction(KIND_DRAIN, 16'hFFFF, 0);
      issue_transaction(KIND_CANCEL, 16'hFFFF, 0);
      issue_transaction(KIND_IGNORED, 16'h0000, 0);
      issue_transaction(KIND_IGNORED, 16'hFFFF, 0);
      issue_transaction(KIND_ADD, 16'h0000, 0);
      issue_transaction(KIND_ADD, 16'hFFFF, 0);
      issue_transaction(KIND_CANCEL, 16'h0000, 0);
      issue_transaction(KIND_CANCEL, 16'hA5A5, 0);
      issue_transaction(KIND_CANCEL, 16'h5A5A, 0);
      issue_transaction(KIND_ADD, 16'hFFFF, 0);
      issue_transaction(KIND_ADD, 16'h1234, 0);
      issue_transaction(KIND_ADD, 16'h5555, 0);
      issue_transaction(KIND_ADD, 16'h5555, 0);
      // The two cancels below revoke 5555 and then pop it again as a repeat.
      issue_transaction(KIND_CANCEL, 16'h0000, 0);
      issue_transaction(KIND_CANCEL, 16'hFFFF, 0);
      issue_transaction(KIND_DRAIN, 16'h0000, 0);
      issue_transaction(KIND_DRAIN, 16'hAAAA, 0);
   endtask

   // Fill the queue past its depth so that adds are dropped. The pushes
   // along the way overflow the undo stack, which the drain does not clear,
   // so later adds keep pushing its oldest entries out.
   task automatic test_queue_full;
      for (int i = 0; i < QDEPTH + 2; i++) issue_transaction(KIND_ADD, JOB_ID_W'($urandom), 0);
      issue_transaction(KIND_DRAIN, JOB_ID_W'($urandom), 0);
      for (int i = 0; i < 5; i++) issue_transaction(KIND_ADD, JOB_ID_W'($urandom), 0);
      for (int i = 0; i < 6; i++) issue_transaction(KIND_CANCEL, JOB_ID_W'($urandom), 0);
      issue_transaction(KIND_DRAIN, JOB_ID_W'($urandom), 0);
   endtask

   // Fill the revoked set. Half of the revoked ids belong to jobs that are
   // already drained, so their marks stay. A later cancel then finds the
   // set full. Adding and draining those ids again clears the set.
   task automatic test_set_full;
      logic [JOB_ID_W-1:0] base;
      base = JOB_ID_W'($urandom_range(16'hFF00));
      issue_transaction(KIND_DRAIN, '0, 0);
      for (int i = 0; i < 16; i++) issue_transaction(KIND_ADD, base + JOB_ID_W'(i), 0);
      issue_transaction(KIND_DRAIN, '0, 0);
      for (int i = 16; i < 32; i++) issue_transaction(KIND_ADD, base + JOB_ID_W'(i), 0);
      for (int i = 0; i < 32; i++) issue_transaction(KIND_CANCEL, '0, 0);
      issue_transaction(KIND_ADD, base + JOB_ID_W'(40), 0);
      issue_transaction(KIND_CANCEL, '0, 0);
      issue_transaction(KIND_CANCEL, '0, 0);
      issue_transaction(KIND_DRAIN, '0, 0);
      for (int i = 0; i < 16; i++) issue_transaction(KIND_ADD, base + JOB_ID_W'(i), 0);
      issue_transaction(KIND_DRAIN, '0, 0);
   endtask

   // Random traffic, weighted toward adds so that the queue builds up
   // between drains. Ids often come from a small pool. Repeats then meet
   // in the revoked set and in the queue. The ignored kind is mixed in as
   // noise and does not count toward the number of transactions.
   task automatic test_random_traffic(input int unsigned count,
                                      input int unsigned idle_pct);
      int unsigned         sent;
      int unsigned         pick;
      logic [JOB_ID_W-1:0] job_id;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         job_id = ($urandom_range(99) < 40) ? id_pool[$urandom_range(7)]
                                            : JOB_ID_W'($urandom);
         if (pick < 55) begin
            issue_transaction(KIND_ADD, job_id, idle_pct);
            sent++;
         end else if (pick < 77) begin
            issue_transaction(KIND_CANCEL, job_id, idle_pct);
            sent++;
         end else if (pick < 93) begin
            issue_transaction(KIND_DRAIN, job_id, idle_pct);
            sent++;
         end else begin
            issue_transaction(KIND_IGNORED, job_id, idle_pct);
         end
      end
   endtask

   // Result checker. A result is strobed for exactly one cycle and is taken
   // at the edge that ends that cycle. Each one must match the oldest
   // prediction that is still waiting.
   always @(posedge clock) begin
      job_outcome_type want;
      if (!reset && rsp_valid) begin
         if (expected_outcomes.size() == 0) begin
            $error("unexpected result: status %0d id %0h", rsp_status, rsp_result_id);
            error_count++;
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_result_id !== want.job_id) begin
               $error("result_id: expected %0h, got %0h", want.job_id, rsp_result_id);
               error_count++;
            end
            if (rsp_printed_count !== want.printed) begin
               $error("printed_count: expected %0d, got %0d", want.printed,
                      rsp_printed_count);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Main sequence. The unit is reset once at the start, and the tests then
   // run one after another without a reset in between.
   initial begin
      int unsigned waited;
      start       = 1'b0;
      reset       = 1'b1;
      req_kind    = KIND_ADD;
      req_job_id  = '0;
      error_count = 0;
      queue_head  = 0;
      queue_fill  = 0;
      undo_top    = 0;
      for (int i = 0; i < RDEPTH; i++) revoked_valid[i] = 1'b0;
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      for (int i = 2; i < 8; i++) id_pool[i] = JOB_ID_W'($urandom);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_queue_full();
      test_set_full();
      // The four phases below are: no idling, a sender idle most of the
      // time, no idling again, and a sender idle now and then. The receiver
      // cannot hold results off, so none of the phases stalls it.
      test_random_traffic(6, 0);
      test_random_traffic(6, 64);
      test_random_traffic(5, 0);
      test_random_traffic(5, 22);
      stop_sending();

      // Let every predicted result arrive, then give the unit time to show
      // any result that should not come.
      waited = 0;
      while (expected_outcomes.size() != 0 && waited < DRAIN_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_outcomes.size() != 0) begin
         $error("%0d expected results never arrived", expected_outcomes.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("job_queue_with_cancel_last_unit_tb OK");
      end else begin
         $display("job_queue_with_cancel_last_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
